[design/ttg_pkg.sv]
// shared types and constants for the four channel timed tone generator
// no dependencies
package ttg_pkg;

  localparam int SYS_CLK_HZ       = 40000000;
  localparam int TICK_DIV         = 16 * 2;
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int MAX_CHANNELS     = 16;
  localparam int OUT_W            = 4;

  localparam int TPM_W  = 16;
  localparam int GAP_W  = 10;
  localparam int HTR_W  = 22;
  localparam int FREQ_W = 15;
  localparam int DUR_W  = 16;
  localparam int CNT_W  = 16;
  localparam int MS_W   = 32;

  localparam logic [TPM_W-1:0]  TICKS_PER_MS_RST   = TPM_W'(2500);
  localparam logic [GAP_W-1:0]  RELEASE_GAP_RST    = GAP_W'(50);
  localparam logic [HTR_W-1:0]  HALF_TICK_RATE_RST = HTR_W'(SYS_CLK_HZ / TICK_DIV);
  localparam logic [FREQ_W-1:0] MIN_FREQ_HZ        = FREQ_W'(20);

  localparam int APB_AW = 4;

  typedef enum logic [1:0] {
    REG_TICKS_PER_MS   = 2'd0,
    REG_RELEASE_GAP    = 2'd1,
    REG_HALF_TICK_RATE = 2'd2
  } reg_idx_t;

  // one channel record as held in the state memory
  typedef struct packed {
    logic [CNT_W-1:0] tick_count;
    logic [CNT_W-1:0] period_value;
    logic [MS_W-1:0]  stop_ms;
  } chan_entry_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

endpackage

[design/ttg_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module ttg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ttg_div.sv]
// restoring divider, one quotient bit per cycle
// depends on ttg_pkg
module ttg_div
  import ttg_pkg::*;
#(
  parameter int DIVIDEND_W = HTR_W,
  parameter int DIVISOR_W  = FREQ_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_W-1:0]     steps;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted  = {rem, quotient[DIVIDEND_W-1]};
  assign fits     = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEP_W'(DIVIDEND_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= DIVISOR_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[DIVISOR_W-1:0];
        end
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        steps    <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/four_channel_timed_tone_generator.sv]
// top level of the four channel timed tone generator
// depends on ttg_pkg, ttg_ram, ttg_div
//
// Each input transfer is either one prescaled tick (mode 0) or a begin-note command
// (mode 1), and each gives exactly one result transfer with the channel levels and the
// active mask after the update. Per-channel tick counter, period and stop time live in
// a small ram with a registered read; a tick steps the millisecond prescaler, which
// advances the millisecond counter when it wraps, and then sweeps the channels one
// per cycle through read, modify and write back. A begin-note command divides
// half_tick_rate by the frequency in a bit-serial divider, one quotient bit per cycle;
// a channel out of range skips the divider. The block takes one item at a time, and
// it takes the next one while a result still waits at the output; a new result waits
// for the previous one to leave, so an output stall holds the block before it takes
// the next input.
module four_channel_timed_tone_generator
  import ttg_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic [1:0]        channel,
  input  logic [FREQ_W-1:0] frequency_hz,
  input  logic [DUR_W-1:0]  duration_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  tone_levels,
  output logic [OUT_W-1:0]  active_mask,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int OUT_PAD = (NUM_CHANNELS > OUT_W) ? NUM_CHANNELS : OUT_W;
  localparam int ENT_W   = $bits(chan_entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [TPM_W-1:0] ticks_per_ms;
  logic [GAP_W-1:0] release_gap_ms;
  logic [HTR_W-1:0] half_tick_rate;

  // global counters and per-channel flags
  logic [MS_W-1:0]          ms_count;
  logic [CNT_W-1:0]         ms_prescale_count;
  logic [NUM_CHANNELS-1:0]  chan_active;
  logic [NUM_CHANNELS-1:0]  chan_level;
  logic [NUM_CHANNELS-1:0]  entry_valid;

  logic [CH_W-1:0]  sweep_ch;
  logic [CH_W-1:0]  note_ch;
  logic [MS_W-1:0]  note_stop;

  // ram side
  logic             ram_we;
  logic [CH_W-1:0]  ram_waddr;
  chan_entry_t      ram_wdata;
  logic             ram_re;
  logic [CH_W-1:0]  ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  chan_entry_t      cur_entry;
  chan_entry_t      sweep_entry;
  logic             sweep_wrap;
  logic             sweep_stop;

  div_ctrl_t        div_ctrl;
  logic [HTR_W-1:0] div_quotient;
  logic [FREQ_W-1:0] div_divisor;
  logic [CNT_W-1:0] period_sat;

  logic             in_xfer;
  logic             cfg_write;
  logic             ch_in_range;
  logic [TPM_W-1:0] ms_limit;
  logic             last_ch;
  logic [OUT_PAD-1:0] level_pad;
  logic [OUT_PAD-1:0] active_pad;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  assign ch_in_range = 32'(channel) < NUM_CHANNELS;
  assign ms_limit    = (ticks_per_ms == '0) ? '0 : ticks_per_ms - TPM_W'(1);
  assign last_ch     = (32'(sweep_ch) == NUM_CHANNELS - 1);

  assign div_divisor    = (frequency_hz < MIN_FREQ_HZ) ? MIN_FREQ_HZ : frequency_hz;
  assign div_ctrl.start = in_xfer && mode && ch_in_range;

  assign period_sat = (div_quotient > HTR_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}}
                                                            : div_quotient[CNT_W-1:0];

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_TICKS_PER_MS:   prdata = 32'(ticks_per_ms);
      REG_RELEASE_GAP:    prdata = 32'(release_gap_ms);
      REG_HALF_TICK_RATE: prdata = 32'(half_tick_rate);
      default:            prdata = '0;
    endcase
  end

  // an entry never written reads as its reset value of zero
  assign cur_entry = entry_valid[sweep_ch] ? chan_entry_t'(ram_rdata) : '0;

  always_comb begin
    sweep_entry = cur_entry;
    sweep_wrap  = cur_entry.tick_count >= cur_entry.period_value;
    sweep_stop  = chan_active[sweep_ch] && (ms_count >= cur_entry.stop_ms);
    if (sweep_wrap) begin
      sweep_entry.tick_count = '0;
      if (sweep_stop) begin
        sweep_entry.stop_ms = '0;
      end
    end else begin
      sweep_entry.tick_count = cur_entry.tick_count + CNT_W'(1);
    end
  end

  // sweep reads one channel ahead of the one being written back
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = sweep_ch;
    ram_wdata = sweep_entry;
    if (state == S_IDLE) begin
      ram_re = in_xfer && !mode;
    end else if (state == S_TICK) begin
      ram_re    = !last_ch;
      ram_raddr = sweep_ch + CH_W'(1);
      ram_we    = 1'b1;
    end else if (state == S_DIV) begin
      ram_we    = div_ctrl.done;
      ram_waddr = note_ch;
      ram_wdata.tick_count   = '0;
      ram_wdata.period_value = period_sat;
      ram_wdata.stop_ms      = note_stop;
    end
  end

  ttg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ttg_div #(
    .DIVIDEND_W (HTR_W),
    .DIVISOR_W  (FREQ_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctrl.start),
    .dividend (half_tick_rate),
    .divisor  (div_divisor),
    .busy     (div_ctrl.busy),
    .done     (div_ctrl.done),
    .quotient (div_quotient)
  );

  assign level_pad  = OUT_PAD'(chan_level);
  assign active_pad = OUT_PAD'(chan_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      ticks_per_ms      <= TICKS_PER_MS_RST;
      release_gap_ms    <= RELEASE_GAP_RST;
      half_tick_rate    <= HALF_TICK_RATE_RST;
      ms_count          <= '0;
      ms_prescale_count <= '0;
      chan_active       <= '0;
      chan_level        <= '0;
      entry_valid       <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_TICKS_PER_MS:   ticks_per_ms   <= pwdata[TPM_W-1:0];
          REG_RELEASE_GAP:    release_gap_ms <= pwdata[GAP_W-1:0];
          REG_HALF_TICK_RATE: half_tick_rate <= pwdata[HTR_W-1:0];
          default: ;
        endcase
      end

      // in S_DONE the output register is reloaded below
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            sweep_ch  <= '0;
            note_ch   <= CH_W'(channel);
            note_stop <= ms_count + (MS_W'(duration_ms) - MS_W'(release_gap_ms));
            if (!mode) begin
              // millisecond counter moves before the channels compare against it
              if (ms_prescale_count >= ms_limit) begin
                ms_prescale_count <= '0;
                ms_count          <= ms_count + MS_W'(1);
              end else begin
                ms_prescale_count <= ms_prescale_count + CNT_W'(1);
              end
              state <= S_TICK;
            end else if (ch_in_range) begin
              state <= S_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_TICK: begin
          entry_valid[sweep_ch] <= 1'b1;
          if (sweep_wrap && chan_active[sweep_ch]) begin
            if (sweep_stop) begin
              chan_level[sweep_ch]  <= 1'b0;
              chan_active[sweep_ch] <= 1'b0;
            end else begin
              chan_level[sweep_ch] <= !chan_level[sweep_ch];
            end
          end
          if (last_ch) begin
            state <= S_DONE;
          end else begin
            sweep_ch <= sweep_ch + CH_W'(1);
          end
        end
        S_DIV: begin
          if (div_ctrl.done) begin
            entry_valid[note_ch] <= 1'b1;
            chan_active[note_ch] <= 1'b1;
            state                <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            tone_levels <= level_pad[OUT_W-1:0];
            active_mask <= active_pad[OUT_W-1:0];
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("block stayed idle after an input transfer");

  a_no_ram_overlap: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("ram read and write hit the same channel");

  a_idle_level_low: assert property (@(posedge clk) disable iff (rst)
    (chan_level & ~chan_active) == '0)
    else $error("idle channel holds a high level");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.done |-> state == S_DIV)
    else $error("divider finished outside a note command");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.start |-> !div_ctrl.busy)
    else $error("divider started while busy");

endmodule
